/* src/assert_macros.svh */
// Assertion macros shared by the warp remap RTL.
// Plain header, no dependencies; simulation builds get the checks, synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define CPWR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset
`define CPWR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define CPWR_ASSERT(label, clk, rst_n, prop, msg)

`define CPWR_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* src/cpwr_pkg.sv */
// Shared types and constants for the cubic polynomial warp remap.
// No dependencies; used by the interfaces, the evaluator and the top level.
package cpwr_pkg;

    // Polynomial shape
    localparam int TERMS      = 10;
    localparam int TERM_W     = 4;
    localparam int IDX_W      = 5;
    localparam int COEF_W     = 64;
    localparam int FRAC_STEP  = 12;   // extra fraction bits per degree
    localparam int OUT_FRAC   = 16;   // fraction bits of the summed result
    localparam int LIM_W      = 13;   // width/height register width
    localparam int PE_STAGES  = 7;    // register stages inside the evaluator

    // Degree of each term slot: 1, x, y, xy, x^2, y^2, x^2y, xy^2, x^3, y^3
    localparam int unsigned TERM_DEGREE [TERMS] = '{0, 1, 1, 2, 2, 2, 3, 3, 3, 3};

    // Configuration port
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [LIM_W-1:0] DIM_RESET = 13'd4096;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MAP  = 1'b1
    } t_cmd;

    // Coefficient write into one polynomial's bank
    typedef struct packed {
        logic                en;
        logic [TERM_W-1:0]   term;
        logic [COEF_W-1:0]   value;
    } t_coef_wr;

endpackage

/* src/cpwr_if.sv */
// Valid/ready stream interfaces for command beats and result beats.
// Depends on cpwr_pkg for field widths.
interface cpwr_cmd_if
    import cpwr_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [COORD_BITS-1:0]    dest_x;
    logic [COORD_BITS-1:0]    dest_y;

    modport source (output valid, command, coef_index, coef_value, dest_x, dest_y,
                    input ready);
    modport sink   (input valid, command, coef_index, coef_value, dest_x, dest_y,
                    output ready);
endinterface

interface cpwr_res_if
    import cpwr_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                    valid;
    logic                    ready;
    logic [COORD_BITS-1:0]   src_x;
    logic [COORD_BITS-1:0]   src_y;
    logic [2*COORD_BITS-1:0] src_address;
    logic                    inside_res;

    modport source (output valid, src_x, src_y, src_address, inside_res, input ready);
    modport sink   (input valid, src_x, src_y, src_address, inside_res, output ready);
endinterface

/* src/cubic_polynomial_warp_remap.sv */
// Top level of the cubic polynomial warp remap: command pipeline, border test, address.
// Depends on cpwr_pkg, cpwr_if (cpwr_cmd_if, cpwr_res_if), cpwr_poly_eval and assert_macros.svh.

// Inverse-mapping address generator. Each command beat either loads one 64-bit
// coefficient (slots 0-9 for the source column, 10-19 for the source row) or maps
// one destination pixel. A map beat gives one result beat: the source column and row
// rounded to the nearest integer, the flat address row*image_width+column, and
// inside_res, which is set only for a source strictly inside the image borders (all
// fields read zero otherwise). A load gives no result. The block takes one beat per
// clock unless the output stalls with the pipeline full; the rate is set by the 12-stage
// pipeline (monomials, four split 32-bit multiplier partial products per term, a product
// merge, a four-level adder tree, border test, address multiply), which moves one beat a
// stage per cycle and closes bubbles under output back-pressure. A load updates the
// coefficient bank in the third stage, so every map beat sent after it sees the new value.
// image_width and image_height are written through the APB port at byte addresses 0
// and 4; the user must write them only while no beat is in flight; the block does not enforce it.
`include "assert_macros.svh"

module cubic_polynomial_warp_remap
    import cpwr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpwr_cmd_if.sink              i_cmd,
    cpwr_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int NSTG        = 12;
    localparam int MONO_W      = 3 * COORD_BITS;
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int ACC_W       = COEF_W + MONO_W + 5;
    localparam int ADDR_W      = 2 * COORD_BITS;
    localparam int ADDR_MIN_W  = 2 * LIM_W + 1;
    localparam int ADDR_CALC_W = (ADDR_MIN_W > ADDR_W) ? ADDR_MIN_W : ADDR_W;
    localparam int EXT_W       = (COORD_BITS > LIM_W) ? COORD_BITS : LIM_W;

    // ---------------- configuration registers ----------------
    logic [LIM_W-1:0] r_image_width;
    logic [LIM_W-1:0] r_image_height;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_RESET;
            r_image_height <= DIM_RESET;
        end else if (cfg_we) begin
            case (paddr[REG_SEL_BIT])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[LIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG-1:0] en_stg;
    t_cmd            r3_cmd;

    // A stage loads when it or any stage downstream holds a bubble, or the output moves
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            en_stg[k] = o_res.ready || ((r_v | ~({NSTG{1'b1}} << k)) != {NSTG{1'b1}});
        end
    end

    // Valid bits; load beats leave the pipe after the coefficient write stage
    always_comb begin
        n_v[0] = en_stg[0] ? i_cmd.valid : r_v[0];
        for (int k = 1; k < NSTG; k++) begin
            if (k == 3) begin
                n_v[k] = en_stg[k] ? (r_v[k-1] && (r3_cmd == CMD_MAP)) : r_v[k];
            end else begin
                n_v[k] = en_stg[k] ? r_v[k-1] : r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_cmd.ready = en_stg[0];

    // ---------------- stage 1: input register ----------------
    t_cmd                  r1_cmd;
    logic [IDX_W-1:0]      r1_idx;
    logic [COEF_W-1:0]     r1_val;
    logic [COORD_BITS-1:0] r1_x;
    logic [COORD_BITS-1:0] r1_y;

    always_ff @(posedge i_clk) begin
        if (en_stg[0]) begin
            r1_cmd <= t_cmd'(i_cmd.command);
            r1_idx <= i_cmd.coef_index;
            r1_val <= i_cmd.coef_value;
            r1_x   <= COORD_BITS'(i_cmd.dest_x);
            r1_y   <= COORD_BITS'(i_cmd.dest_y);
        end
    end

    // ---------------- stage 2: second-order monomials ----------------
    t_cmd                  r2_cmd;
    logic [IDX_W-1:0]      r2_idx;
    logic [COEF_W-1:0]     r2_val;
    logic [COORD_BITS-1:0] r2_x;
    logic [COORD_BITS-1:0] r2_y;
    logic [SQ_W-1:0]       r2_xy;
    logic [SQ_W-1:0]       r2_xx;
    logic [SQ_W-1:0]       r2_yy;

    always_ff @(posedge i_clk) begin
        if (en_stg[1]) begin
            r2_cmd <= r1_cmd;
            r2_idx <= r1_idx;
            r2_val <= r1_val;
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_xy  <= SQ_W'(r1_x) * SQ_W'(r1_y);
            r2_xx  <= SQ_W'(r1_x) * SQ_W'(r1_x);
            r2_yy  <= SQ_W'(r1_y) * SQ_W'(r1_y);
        end
    end

    // ---------------- stage 3: all ten monomials ----------------
    logic [IDX_W-1:0]               r3_idx;
    logic [COEF_W-1:0]              r3_val;
    logic [TERMS-1:0][MONO_W-1:0]   r3_mono;

    always_ff @(posedge i_clk) begin
        if (en_stg[2]) begin
            r3_cmd     <= r2_cmd;
            r3_idx     <= r2_idx;
            r3_val     <= r2_val;
            // slot order: 1, x, y, xy, x^2, y^2, x^2y, xy^2, x^3, y^3
            r3_mono[0] <= MONO_W'(1);
            r3_mono[1] <= MONO_W'(r2_x);
            r3_mono[2] <= MONO_W'(r2_y);
            r3_mono[3] <= MONO_W'(r2_xy);
            r3_mono[4] <= MONO_W'(r2_xx);
            r3_mono[5] <= MONO_W'(r2_yy);
            r3_mono[6] <= MONO_W'(r2_xx) * MONO_W'(r2_y);
            r3_mono[7] <= MONO_W'(r2_yy) * MONO_W'(r2_x);
            r3_mono[8] <= MONO_W'(r2_xx) * MONO_W'(r2_x);
            r3_mono[9] <= MONO_W'(r2_yy) * MONO_W'(r2_y);
        end
    end

    // Coefficient write as the load beat leaves stage 3; out-of-range slots are dropped
    logic     ld_go;
    t_coef_wr wr_x;
    t_coef_wr wr_y;

    assign ld_go = r_v[2] && (r3_cmd == CMD_LOAD) && en_stg[3];

    always_comb begin
        wr_x.en    = ld_go && (r3_idx < IDX_W'(TERMS));
        wr_x.term  = r3_idx[TERM_W-1:0];
        wr_x.value = r3_val;
        wr_y.en    = ld_go && (r3_idx >= IDX_W'(TERMS)) && (r3_idx < IDX_W'(2 * TERMS));
        wr_y.term  = TERM_W'(r3_idx - IDX_W'(TERMS));
        wr_y.value = r3_val;
    end

    // ---------------- stages 4..10: polynomial evaluators ----------------
    logic signed [ACC_W-1:0] sum_x;
    logic signed [ACC_W-1:0] sum_y;

    cpwr_poly_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_poly_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (en_stg[3+PE_STAGES-1:3]),
        .i_wr    (wr_x),
        .i_mono  (r3_mono),
        .o_sum   (sum_x)
    );

    cpwr_poly_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_poly_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (en_stg[3+PE_STAGES-1:3]),
        .i_wr    (wr_y),
        .i_mono  (r3_mono),
        .o_sum   (sum_y)
    );

    // ---------------- stage 11: rounding and border test ----------------
    logic [LIM_W-1:0] rnd_x;
    logic [LIM_W-1:0] rnd_y;
    logic             in_x;
    logic             in_y;
    logic [LIM_W-1:0] r11_sx;
    logic [LIM_W-1:0] r11_sy;
    logic             r11_in;

    // Rounded value is sum >>> 16; inside means 0 < v and v + 1 < limit
    always_comb begin
        rnd_x = sum_x[OUT_FRAC+LIM_W-1:OUT_FRAC];
        rnd_y = sum_y[OUT_FRAC+LIM_W-1:OUT_FRAC];
        in_x  = (sum_x[ACC_W-1:OUT_FRAC+LIM_W] == '0) && (rnd_x != '0)
             && (({1'b0, rnd_x} + (LIM_W+1)'(1)) < {1'b0, r_image_width});
        in_y  = (sum_y[ACC_W-1:OUT_FRAC+LIM_W] == '0) && (rnd_y != '0)
             && (({1'b0, rnd_y} + (LIM_W+1)'(1)) < {1'b0, r_image_height});
    end

    always_ff @(posedge i_clk) begin
        if (en_stg[10]) begin
            r11_sx <= rnd_x;
            r11_sy <= rnd_y;
            r11_in <= in_x && in_y;
        end
    end

    // ---------------- stage 12: address and output register ----------------
    logic [EXT_W-1:0]       sx_ext;
    logic [EXT_W-1:0]       sy_ext;
    logic [ADDR_CALC_W-1:0] addr_full;
    logic [COORD_BITS-1:0]  r_src_x;
    logic [COORD_BITS-1:0]  r_src_y;
    logic [ADDR_W-1:0]      r_src_address;
    logic                   r_inside;

    always_comb begin
        sx_ext    = EXT_W'(r11_sx);
        sy_ext    = EXT_W'(r11_sy);
        addr_full = ADDR_CALC_W'(r11_sy) * ADDR_CALC_W'(r_image_width)
                  + ADDR_CALC_W'(r11_sx);
    end

    always_ff @(posedge i_clk) begin
        if (en_stg[11]) begin
            r_src_x       <= r11_in ? sx_ext[COORD_BITS-1:0] : '0;
            r_src_y       <= r11_in ? sy_ext[COORD_BITS-1:0] : '0;
            r_src_address <= r11_in ? addr_full[ADDR_W-1:0] : '0;
            r_inside      <= r11_in;
        end
    end

    assign o_res.valid       = r_v[NSTG-1];
    assign o_res.src_x       = r_src_x;
    assign o_res.src_y       = r_src_y;
    assign o_res.src_address = r_src_address;
    assign o_res.inside_res  = r_inside;

    // ---------------- assertions ----------------
    `CPWR_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !i_cmd.ready |-> (&r_v), "input stalled while the pipeline holds a bubble")
    `CPWR_ASSERT(a_load_leaves_pipe, i_clk, i_rst_n, ld_go |=> !r_v[3], "load beat carried past the coefficient write stage")
    `CPWR_ASSERT_NEVER(a_outside_nonzero, i_clk, i_rst_n, o_res.valid && !o_res.inside_res && (o_res.src_x != '0 || o_res.src_y != '0 || o_res.src_address != '0), "outside result carries nonzero coordinates")
    `CPWR_ASSERT_NEVER(a_dual_write, i_clk, i_rst_n, wr_x.en && wr_y.en, "one load wrote both coefficient banks")

endmodule

/* src/cpwr_poly_eval.sv */
// One bivariate cubic polynomial: coefficient bank, split multipliers and adder tree.
// Depends on cpwr_pkg; stage enables and monomials come from the top level.
module cpwr_poly_eval
    import cpwr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [PE_STAGES-1:0]                 i_adv,
    input  t_coef_wr                             i_wr,
    input  logic [TERMS-1:0][3*COORD_BITS-1:0]   i_mono,
    output logic signed [COEF_W+3*COORD_BITS+4:0] o_sum
);
    localparam int MONO_W = 3 * COORD_BITS;
    localparam int ML_W   = (MONO_W + 1) / 2;
    localparam int MH_W   = MONO_W - ML_W;
    localparam int HALF_W = COEF_W / 2;
    localparam int PLL_W  = HALF_W + ML_W;
    localparam int PLH_W  = HALF_W + MH_W;
    localparam int PHL_W  = HALF_W + ML_W + 1;
    localparam int PHH_W  = HALF_W + MH_W + 1;
    localparam int LO_W   = HALF_W + MONO_W;
    localparam int HI_W   = HALF_W + MONO_W + 1;
    localparam int PROD_W = COEF_W + MONO_W + 1;
    localparam int ACC_W  = PROD_W + 4;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-OUT_FRAC){1'b0}}, 1'b1, {(OUT_FRAC-1){1'b0}}};

    logic [COEF_W-1:0] r_coef [TERMS];

    logic [PLL_W-1:0]        r_pp_ll [TERMS];
    logic [PLH_W-1:0]        r_pp_lh [TERMS];
    logic signed [PHL_W-1:0] r_pp_hl [TERMS];
    logic signed [PHH_W-1:0] r_pp_hh [TERMS];
    logic [PLL_W-1:0]        n_pp_ll [TERMS];
    logic [PLH_W-1:0]        n_pp_lh [TERMS];
    logic signed [PHL_W-1:0] n_pp_hl [TERMS];
    logic signed [PHH_W-1:0] n_pp_hh [TERMS];

    logic [LO_W-1:0]          r_lo [TERMS];
    logic signed [HI_W-1:0]   r_hi [TERMS];
    logic [LO_W-1:0]          n_lo [TERMS];
    logic signed [HI_W-1:0]   n_hi [TERMS];

    logic signed [PROD_W-1:0] n_prod [TERMS];
    logic signed [PROD_W-1:0] r_term [TERMS];

    logic signed [ACC_W-1:0]  r_s1 [5];
    logic signed [ACC_W-1:0]  r_s2 [3];
    logic signed [ACC_W-1:0]  r_s3 [2];
    logic signed [ACC_W-1:0]  r_sum;

    // Coefficient bank, reset to zero, one write per load beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TERMS; t++) begin
                r_coef[t] <= '0;
            end
        end else if (i_wr.en) begin
            r_coef[i_wr.term] <= i_wr.value;
        end
    end

    // Partial products: 64-bit coefficient split in halves, monomial split in halves
    always_comb begin
        for (int t = 0; t < TERMS; t++) begin
            n_pp_ll[t] = PLL_W'(r_coef[t][HALF_W-1:0]) * PLL_W'(i_mono[t][ML_W-1:0]);
            n_pp_lh[t] = PLH_W'(r_coef[t][HALF_W-1:0]) * PLH_W'(i_mono[t][MONO_W-1:ML_W]);
            n_pp_hl[t] = PHL_W'($signed(r_coef[t][COEF_W-1:HALF_W]))
                       * PHL_W'($signed({1'b0, i_mono[t][ML_W-1:0]}));
            n_pp_hh[t] = PHH_W'($signed(r_coef[t][COEF_W-1:HALF_W]))
                       * PHH_W'($signed({1'b0, i_mono[t][MONO_W-1:ML_W]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            for (int t = 0; t < TERMS; t++) begin
                r_pp_ll[t] <= n_pp_ll[t];
                r_pp_lh[t] <= n_pp_lh[t];
                r_pp_hl[t] <= n_pp_hl[t];
                r_pp_hh[t] <= n_pp_hh[t];
            end
        end
    end

    // Merge the monomial halves
    always_comb begin
        for (int t = 0; t < TERMS; t++) begin
            n_lo[t] = LO_W'(r_pp_ll[t]) + (LO_W'(r_pp_lh[t]) << ML_W);
            n_hi[t] = HI_W'(r_pp_hl[t]) + (HI_W'(r_pp_hh[t]) <<< ML_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            for (int t = 0; t < TERMS; t++) begin
                r_lo[t] <= n_lo[t];
                r_hi[t] <= n_hi[t];
            end
        end
    end

    // Full product, then floor shift into Q.16
    always_comb begin
        for (int t = 0; t < TERMS; t++) begin
            n_prod[t] = PROD_W'($signed({1'b0, r_lo[t]})) + (PROD_W'(r_hi[t]) <<< HALF_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            for (int t = 0; t < TERMS; t++) begin
                r_term[t] <= n_prod[t] >>> (FRAC_STEP * TERM_DEGREE[t]);
            end
        end
    end

    // Adder tree: 10 -> 5 -> 3 -> 2 -> 1, rounding half folded in at level three
    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            for (int i = 0; i < 5; i++) begin
                r_s1[i] <= ACC_W'(r_term[2*i]) + ACC_W'(r_term[2*i+1]);
            end
        end
        if (i_adv[4]) begin
            r_s2[0] <= r_s1[0] + r_s1[1];
            r_s2[1] <= r_s1[2] + r_s1[3];
            r_s2[2] <= r_s1[4];
        end
        if (i_adv[5]) begin
            r_s3[0] <= r_s2[0] + r_s2[1];
            r_s3[1] <= r_s2[2] + ROUND_HALF;
        end
        if (i_adv[6]) begin
            r_sum <= r_s3[0] + r_s3[1];
        end
    end

    assign o_sum = r_sum;

endmodule
